FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, sampled on clk, off during rst
`define PNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication, sampled on clk, off during rst
`define PNF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pnf_pkg.sv
// types and constants for the point set nearest/farthest block
`default_nettype none

package pnf_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = 33;
  localparam int KIND_BITS  = 3;
  localparam int STAT_BITS  = 3;

  typedef enum logic [KIND_BITS-1:0] {
    K_INSERT   = 3'd0,
    K_REMOVE   = 3'd1,
    K_MEMBER   = 3'd2,
    K_NEAREST  = 3'd3,
    K_FARTHEST = 3'd4
  } kind_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_ABSENT = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] z;
  } point_t;

  // tag that travels with each read of the scan
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [IDX_BITS-1:0] idx;
  } scan_t;

  // one scanned entry after the distance unit
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                eq;
    logic [IDX_BITS-1:0] idx;
    point_t              pt;
    logic [SQ_BITS-1:0]  sq_x;
    logic [SQ_BITS-1:0]  sq_z;
  } dist_res_t;

  typedef struct packed {
    status_t               status;
    logic                  hit;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] z;
    logic [DIST_BITS-1:0]  dist_sq;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pnf_req_if.sv
// request channel: operation kind and point coordinates
`default_nettype none

interface pnf_req_if;
  import pnf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] z_coord;

  modport source (output valid, output kind, output x_coord, output z_coord, input ready);
  modport sink   (input valid, input kind, input x_coord, input z_coord, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pnf_rsp_if.sv
// response channel: status, hit flag and chosen point with its distance
`default_nettype none

interface pnf_rsp_if;
  import pnf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAT_BITS-1:0]  status;
  logic                  hit;
  logic [COORD_BITS-1:0] result_x;
  logic [COORD_BITS-1:0] result_z;
  logic [DIST_BITS-1:0]  distance_sq;

  modport source (output valid, output status, output hit, output result_x,
                  output result_z, output distance_sq, input ready);
  modport sink   (input valid, input status, input hit, input result_x,
                  input result_z, input distance_sq, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/point_set_nearest_farthest.sv
// top level: ordered point set with nearest and farthest linear search
// an empty set skips the scan and an unknown kind goes straight to the response;
//   a remove closes the gap by moving each later entry up one place
// one transaction at a time: a new request is taken only once the last response is loaded,
//   and the scan and the gap closing share the single storage read port
// reset: synchronous, empties the set; point storage itself is not cleared
`default_nettype none
`include "assert_macros.svh"

module point_set_nearest_farthest (
  input  logic     clk,
  input  logic     rst,
  pnf_req_if.sink  req,
  pnf_rsp_if.source rsp
);
  import pnf_pkg::*;

  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_POINTS);

  state_t                state, state_next;

  // captured request
  logic [KIND_BITS-1:0]  kind_q;
  point_t                query;

  // scan bookkeeping
  logic [IDX_BITS-1:0]   iss;
  scan_t                 scan;
  logic                  match;
  logic [IDX_BITS-1:0]   pos;
  logic                  found;
  logic [DIST_BITS-1:0]  best;
  point_t                best_pt;
  logic [IDX_BITS-1:0]   sh;
  logic [CNT_BITS-1:0]   count;

  // result staging and the output register
  result_t               pend;
  result_t               out_q;
  logic                  out_valid;

  // storage ports
  logic                  rd_en;
  logic [IDX_BITS-1:0]   rd_addr;
  point_t                rd_pt;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  point_t                wr_pt;

  dist_res_t             res;
  logic [DIST_BITS-1:0]  dist_sq;
  logic                  take;
  logic                  scan_end;
  logic                  shift_more;
  logic                  shift_last;
  logic                  accept;
  logic                  load_out;

  pnf_point_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_pt   (wr_pt),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_pt   (rd_pt)
  );

  // read data and its tag are each registered once, so they line up in the cycle after the issue
  pnf_dist_unit u_dist (
    .clk     (clk),
    .rst     (rst),
    .scan_in (scan),
    .pt      (rd_pt),
    .query   (query),
    .res     (res)
  );

  assign accept     = req.valid && req.ready;
  assign load_out   = (state == S_RESULT) && (!out_valid || rsp.ready);
  assign scan_end   = (CNT_BITS'(iss) == count - 1'b1);
  // gap closing is needed when the removed entry is not the last one
  assign shift_more = (CNT_BITS'(pos) + 1'b1 < count);
  // the entry just moved was the last stored one
  assign shift_last = (CNT_BITS'(sh) + CNT_BITS'(2) >= count);

  // one wide add and compare against the running best
  assign dist_sq = DIST_BITS'(res.sq_x) + DIST_BITS'(res.sq_z);
  // strict compares keep the earliest entry on a tie; farthest starts at zero
  assign take = (kind_q == K_NEAREST) ? (!found || dist_sq < best) : (dist_sq > best);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.kind > K_FARTHEST) begin
            state_next = S_RESULT;
          end else if (count == '0) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (res.valid && res.last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (kind_q == K_REMOVE && match && shift_more) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (shift_last) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_RESULT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // storage port control and request ready
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = iss;
    wr_en     = 1'b0;
    wr_addr   = sh;
    wr_pt     = rd_pt;
    case (state)
      S_IDLE: req.ready = 1'b1;
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = iss;
      end
      S_FINISH: begin
        // insert lands at the end of the set
        wr_en   = (kind_q == K_INSERT) && !match && (count != CNT_MAX);
        wr_addr = count[IDX_BITS-1:0];
        wr_pt   = query;
      end
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = sh + 1'b1;
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh;
        wr_pt   = rd_pt;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      scan.valid <= 1'b0;
    end else begin
      state      <= state_next;
      scan.valid <= (state == S_SCAN);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_FINISH) begin
        if (kind_q == K_INSERT && !match && count != CNT_MAX) begin
          count <= count + 1'b1;
        end else if (kind_q == K_REMOVE && match && !shift_more) begin
          count <= count - 1'b1;
        end
      end else if (state == S_SHIFT_WR && shift_last) begin
        count <= count - 1'b1;
      end
    end
    // tag for the read issued this cycle
    scan.last <= (state == S_SCAN) && scan_end;
    scan.idx  <= iss;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_q <= pend;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          kind_q  <= req.kind;
          query.x <= req.x_coord;
          query.z <= req.z_coord;
          iss     <= '0;
          match   <= 1'b0;
          found   <= 1'b0;
          best    <= '0;
          pend    <= '0;
        end
      end
      S_SCAN, S_DRAIN: begin
        if (state == S_SCAN) begin
          iss <= iss + 1'b1;
        end
        if (res.valid) begin
          // first equal entry gives the position for remove
          if (res.eq && !match) begin
            match <= 1'b1;
            pos   <= res.idx;
          end
          if (take) begin
            found   <= 1'b1;
            best    <= dist_sq;
            best_pt <= res.pt;
          end
        end
      end
      S_FINISH: begin
        case (kind_q)
          K_INSERT: begin
            if (match) begin
              pend.status <= ST_DUP;
            end else if (count == CNT_MAX) begin
              pend.status <= ST_FULL;
            end
          end
          K_REMOVE: begin
            if (!match) begin
              pend.status <= ST_ABSENT;
            end
            sh <= pos;
          end
          K_MEMBER: pend.hit <= match;
          K_NEAREST, K_FARTHEST: begin
            if (found) begin
              pend.x       <= best_pt.x;
              pend.z       <= best_pt.z;
              pend.dist_sq <= best;
            end else begin
              pend.status <= ST_EMPTY;
            end
          end
          default: pend.status <= ST_OK;
        endcase
      end
      S_SHIFT_WR: sh <= sh + 1'b1;
      default: sh <= sh;
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_q.status;
  assign rsp.hit         = out_q.hit;
  assign rsp.result_x    = out_q.x;
  assign rsp.result_z    = out_q.z;
  assign rsp.distance_sq = out_q.dist_sq;

  // the set never grows past its capacity
  `PNF_ASSERT(a_count_cap, count <= CNT_MAX, "point count above capacity")
  // scan results only come back while a scan is running
  `PNF_ASSERT_IMP(a_res_in_scan, res.valid, state == S_SCAN || state == S_DRAIN, "stray scan result")
  // gap closing never reads beyond the stored points
  `PNF_ASSERT_IMP(a_shift_bound, state == S_SHIFT_RD, CNT_BITS'(sh) + 1'b1 < count, "shift past end")
  // the count moves only on an insert/remove decision or the last move of a gap
  `PNF_ASSERT_IMP(a_count_move, !$stable(count), $past(state) == S_FINISH || $past(state) == S_SHIFT_WR, "count changed outside update")

endmodule

`default_nettype wire

FILE: hw/rtl/pnf_point_mem.sv
// point storage: one write port, one registered read port
`default_nettype none

module pnf_point_mem (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [pnf_pkg::IDX_BITS-1:0] wr_addr,
  input  pnf_pkg::point_t         wr_pt,
  input  logic                    rd_en,
  input  logic [pnf_pkg::IDX_BITS-1:0] rd_addr,
  output pnf_pkg::point_t         rd_pt
);
  import pnf_pkg::*;

  point_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pt <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pnf_dist_unit.sv
// two-stage distance unit: absolute differences, then squares
`default_nettype none

module pnf_dist_unit (
  input  logic               clk,
  input  logic               rst,
  input  pnf_pkg::scan_t     scan_in,
  input  pnf_pkg::point_t    pt,
  input  pnf_pkg::point_t    query,
  output pnf_pkg::dist_res_t res
);
  import pnf_pkg::*;

  scan_t                 s1;
  point_t                s1_pt;
  logic                  s1_eq;
  logic [COORD_BITS-1:0] s1_dx;
  logic [COORD_BITS-1:0] s1_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      s1.valid  <= scan_in.valid;
      res.valid <= s1.valid;
    end

    // stage one: differences and the equality test
    s1.last <= scan_in.last;
    s1.idx  <= scan_in.idx;
    s1_pt   <= pt;
    s1_eq   <= (pt.x == query.x) && (pt.z == query.z);
    s1_dx   <= (pt.x >= query.x) ? (pt.x - query.x) : (query.x - pt.x);
    s1_dz   <= (pt.z >= query.z) ? (pt.z - query.z) : (query.z - pt.z);

    // stage two: squares
    res.last <= s1.last;
    res.idx  <= s1.idx;
    res.eq   <= s1_eq;
    res.pt   <= s1_pt;
    res.sq_x <= SQ_BITS'(s1_dx) * SQ_BITS'(s1_dx);
    res.sq_z <= SQ_BITS'(s1_dz) * SQ_BITS'(s1_dz);
  end

endmodule

`default_nettype wire
